/* rtl/core/uaf_pkg.sv */
// ============================================================================
// uaf_pkg
// Shared types and constants for the UTF-8 to ASCII folding block.
// ============================================================================
package uaf_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned COUNT_W = 8;

   // Match mode, one-hot
   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,  // no pending lead byte
      MODE_C2   = 5'b00010,  // C2 seen
      MODE_E2   = 5'b00100,  // E2 seen
      MODE_E282 = 5'b01000,  // E2 82 seen
      MODE_SKIP = 5'b10000   // dropping continuation bytes
   } mode_type;

   localparam logic [BYTE_W-1:0] LEAD_C2   = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD_E2   = 8'hE2;
   localparam logic [BYTE_W-1:0] TRAIL_B0  = 8'hB0;
   localparam logic [BYTE_W-1:0] TRAIL_B2  = 8'hB2;
   localparam logic [BYTE_W-1:0] TRAIL_B3  = 8'hB3;
   localparam logic [BYTE_W-1:0] TRAIL_B5  = 8'hB5;
   localparam logic [BYTE_W-1:0] TRAIL_82  = 8'h82;
   localparam logic [BYTE_W-1:0] TRAIL_83  = 8'h83;
   localparam logic [1:0]        CONT_TAG  = 2'b10;   // top bits of 10xxxxxx

   localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_U    = 7'h75;   // 'u'
   localparam logic [CHAR_W-1:0] CHAR_TWO  = 7'h32;   // '2'
   localparam logic [CHAR_W-1:0] CHAR_THREE = 7'h33;  // '3'

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd15;

endpackage

/* rtl/core/utf8_ascii_fold.sv */
// ============================================================================
// utf8_ascii_fold
// Streaming UTF-8 to plain ASCII folding, one source byte per item.
// ============================================================================
//
//  channel | dir | tdata (low bit up)              | tuser/tlast
//  --------+-----+---------------------------------+-----------------------
//  req_    | in  | [7:0] in_byte                   | tlast = string_end
//  rsp_    | out | [6:0] out_char, [7] zero         | tlast = is_end
//  csr_    | in  | [7:0] output_limit              | (always ready)
//
//  rsp valid is registered after req acceptance (input register, then
//  result register); one item per cycle sustained while rsp is taken,
//  set by the mode register loop.
//  Items that yield no character leave the input register without a result.
//  A stalled result holds the result and input registers; the result register frees
//  in the same cycle it is taken, so there is no bubble.
//  Reset clears the mode, count and valid flags and sets the limit to 15.
//
module utf8_ascii_fold
   import uaf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // source bytes
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,   // string_end
   // folded characters
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic              rsp_tlast,   // is_end
   // output limit register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [COUNT_W-1:0] csr_data    // [7:0] output_limit
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // string state
   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] limit_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff;
   logic              out_end_ff;

   logic              out_free;
   logic              advance;
   logic              in_take;
   logic              is_cont;
   logic              is_term;
   logic [CHAR_W-1:0] fold_char;
   logic [CHAR_W-1:0] res_char;
   logic              emit;

   // The item in the input register moves on whenever the result slot is free
   // (empty or being taken now), whether or not it produces a character.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign in_take    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = in_take || (in_valid_ff && !advance);

   // ---- folding logic ----
   assign is_cont = (in_byte_ff[7:6] == CONT_TAG);
   assign is_term = in_last_ff || (in_byte_ff == '0);

   always_comb begin
      logic fresh;
      fresh     = 1'b0;
      fold_char = CHAR_NONE;
      mode_in   = mode_ff;
      case (mode_ff)
         MODE_C2: begin
            if (!is_cont) begin
               fresh = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
               if (in_byte_ff == TRAIL_B5)      fold_char = CHAR_U;
               else if (in_byte_ff == TRAIL_B2) fold_char = CHAR_TWO;
               else if (in_byte_ff == TRAIL_B3) fold_char = CHAR_THREE;
               else if (in_byte_ff != TRAIL_B0) mode_in   = MODE_SKIP;
            end
         end
         MODE_E2: begin
            if (!is_cont) fresh = 1'b1;
            else mode_in = (in_byte_ff == TRAIL_82) ? MODE_E282 : MODE_SKIP;
         end
         MODE_E282: begin
            if (!is_cont) begin
               fresh = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
               if (in_byte_ff == TRAIL_82)      fold_char = CHAR_TWO;
               else if (in_byte_ff == TRAIL_83) fold_char = CHAR_THREE;
               else                             mode_in   = MODE_SKIP;
            end
         end
         MODE_SKIP: begin
            if (!is_cont) fresh = 1'b1;
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      // a byte handled as if idle: ASCII passes, known leads arm a match
      if (fresh) begin
         if (!in_byte_ff[7]) begin
            mode_in   = MODE_IDLE;
            fold_char = in_byte_ff[CHAR_W-1:0];
         end else if (in_byte_ff == LEAD_C2) begin
            mode_in = MODE_C2;
         end else if (in_byte_ff == LEAD_E2) begin
            mode_in = MODE_E2;
         end else begin
            mode_in = MODE_SKIP;
         end
      end

      count_in = count_ff;
      emit     = 1'b0;
      res_char = fold_char;
      if (is_term) begin
         // terminator always goes out and restarts the string
         mode_in  = MODE_IDLE;
         count_in = '0;
         emit     = 1'b1;
         res_char = CHAR_NONE;
      end else if ((fold_char != CHAR_NONE) && (count_ff < limit_ff)) begin
         count_in = count_ff + 1'b1;
         emit     = 1'b1;
      end
   end

   assign out_valid_in = advance ? emit : (out_valid_ff && !rsp_tready);

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) limit_ff <= csr_data;
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && emit) begin
         out_char_ff <= res_char;
         out_end_ff  <= is_term;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_end_ff;

endmodule

/* rtl/core/uaf_checker.sv */
// ============================================================================
// uaf_checker
// Port-level checks for utf8_ascii_fold, bound to the top level.
// ============================================================================
module uaf_checker
   import uaf_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [BYTE_W-1:0] rsp_tdata,
   input logic              rsp_tlast,
   input logic              csr_ready
);

   // held result must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // output is 7-bit ASCII
   a_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[BYTE_W-1])
      else $error("non-ASCII result");

   // terminator carries a zero character, any other result a nonzero one
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata == '0)))
      else $error("terminator and zero character disagree");

   // reset empties the result register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

endmodule

bind utf8_ascii_fold uaf_checker u_uaf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);

/* tb/fold_checker.sv */
// ----------------------------------------------------------------------------
// fold_checker
// Watches the byte, character and limit channels of utf8_ascii_fold, folds
// every accepted byte in its own copy of the match logic and compares each
// character item with the oldest one predicted.
// ----------------------------------------------------------------------------
module fold_checker
   import uaf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [BYTE_W-1:0]  req_tdata,   // [7:0] in_byte
   input  logic               req_tlast,   // string_end
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [BYTE_W-1:0]  rsp_tdata,   // [6:0] out_char, [7] zero
   input  logic               rsp_tlast,   // is_end
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data,    // [7:0] output_limit
   output int                 mismatch_count,
   output int                 waiting_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              is_end;
   } fold_item_type;

   fold_item_type      folded_q[$];
   mode_type           fold_mode;
   logic [COUNT_W-1:0] emit_count;
   logic [COUNT_W-1:0] limit_reg;
   int                 error_tally = 0;
   fold_item_type      want;
   logic [CHAR_W-1:0]  next_char;

   function automatic logic is_trail(input logic [BYTE_W-1:0] b);
      return b[7:6] == CONT_TAG;
   endfunction

   // byte seen with no lead pending
   function automatic logic [CHAR_W-1:0] start_char(input logic [BYTE_W-1:0] b);
      if (!b[7]) begin
         fold_mode = MODE_IDLE;
         return b[CHAR_W-1:0];
      end
      if (b == LEAD_C2)
         fold_mode = MODE_C2;
      else if (b == LEAD_E2)
         fold_mode = MODE_E2;
      else
         fold_mode = MODE_SKIP;
      return CHAR_NONE;
   endfunction

   function automatic logic [CHAR_W-1:0] fold_char(input logic [BYTE_W-1:0] b);
      logic [CHAR_W-1:0] ch;
      ch = CHAR_NONE;
      // a non-continuation byte breaks any pending match
      if (fold_mode != MODE_IDLE && !is_trail(b))
         return start_char(b);
      case (fold_mode)
         MODE_C2: begin
            fold_mode = MODE_IDLE;
            if (b == TRAIL_B5)
               ch = CHAR_U;
            else if (b == TRAIL_B2)
               ch = CHAR_TWO;
            else if (b == TRAIL_B3)
               ch = CHAR_THREE;
            else if (b != TRAIL_B0)
               fold_mode = MODE_SKIP;
         end
         MODE_E2: fold_mode = (b == TRAIL_82) ? MODE_E282 : MODE_SKIP;
         MODE_E282: begin
            fold_mode = MODE_IDLE;
            if (b == TRAIL_82)
               ch = CHAR_TWO;
            else if (b == TRAIL_83)
               ch = CHAR_THREE;
            else
               fold_mode = MODE_SKIP;
         end
         MODE_SKIP: ch = CHAR_NONE;
         default: ch = start_char(b);
      endcase
      return ch;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fold_mode  = MODE_IDLE;
         emit_count = '0;
         limit_reg  = LIMIT_RESET;
         folded_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (folded_q.size() == 0) begin
               error_tally++;
               $display("%0t ns: unexpected item, expected none, got char 0x%02h end %0b",
                        $time, rsp_tdata[CHAR_W-1:0], rsp_tlast);
            end else begin
               want = folded_q.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== want.out_char) begin
                  error_tally++;
                  $display("%0t ns: out_char expected 0x%02h, got 0x%02h",
                           $time, want.out_char, rsp_tdata[CHAR_W-1:0]);
               end
               if (rsp_tlast !== want.is_end) begin
                  error_tally++;
                  $display("%0t ns: is_end expected %0b, got %0b",
                           $time, want.is_end, rsp_tlast);
               end
            end
         end
         if (csr_valid && csr_ready)
            limit_reg = csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tlast || req_tdata == NUL_BYTE) begin
               // terminator always goes out and clears the string state
               folded_q.push_back('{out_char: CHAR_NONE, is_end: 1'b1});
               fold_mode  = MODE_IDLE;
               emit_count = '0;
            end else begin
               next_char = fold_char(req_tdata);
               if (next_char != CHAR_NONE && emit_count < limit_reg) begin
                  emit_count = emit_count + 1'b1;
                  folded_q.push_back('{out_char: next_char, is_end: 1'b0});
               end
            end
         end
      end
      waiting_count  <= folded_q.size();
      mismatch_count <= error_tally;
   end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives UTF-8 strings into utf8_ascii_fold: a directed pass over every
// folded sequence and broken match, then random strings under several output
// limits, with random idling on both sides and one long result stall.
// fold_checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
   import uaf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;  // far above the slowest legal run
   localparam int HOLD_CYCLES = 300;     // long receiver stall
   localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata  = '0;   // [7:0] in_byte
   logic               req_tlast  = 1'b0; // string_end
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [BYTE_W-1:0]  rsp_tdata;         // [6:0] out_char, [7] zero
   logic               rsp_tlast;         // is_end
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data   = '0;   // [7:0] output_limit

   int   mismatch_count;
   int   waiting_count;
   int   cycle_count = 0;
   int   req_sent    = 0;
   logic tx_eager    = 1'b0;  // sender skips its idle draws
   logic rx_eager    = 1'b0;  // receiver skips its idle draws
   int   hold_ask    = 0;     // bumped by stimulus to request a long stall

   always #2 clock = ~clock;

   utf8_ascii_fold dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   fold_checker fold_chk (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("utf8_ascii_fold: mismatch");
         $finish;
      end
   end

   // Result side: per item a random wait, sometimes none for a stretch.
   // A bump of hold_ask makes it hold off once for the long stall.
   initial begin : receiver
      int gap;
      int hold_seen;
      hold_seen = 0;
      forever begin
         if ($urandom_range(0, 39) == 0)
            rx_eager = !rx_eager;
         gap = rx_eager ? 0 : $urandom_range(0, 15);
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // One source byte. tvalid is dropped only when an idle gap is drawn, so a
   // back-to-back item keeps it high without a second assignment in the step.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      gap = tx_eager ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      req_sent++;
   endtask

   // Stop offering, wait until every predicted item is out, then let the
   // pipeline drain bytes that yield no item.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (waiting_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(input logic [COUNT_W-1:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_cont();
      send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
   endtask

   // One random piece of a string: mostly well-formed, some near misses,
   // truncated sequences and raw noise.
   task automatic send_token();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         send_byte(8'($urandom_range(1, 127)), 1'b0);
      end else if (kind < 60) begin
         // one of the folded sequences
         case ($urandom_range(0, 5))
            0: begin send_byte(LEAD_C2, 1'b0); send_byte(TRAIL_B0, 1'b0); end
            1: begin send_byte(LEAD_C2, 1'b0); send_byte(TRAIL_B5, 1'b0); end
            2: begin send_byte(LEAD_C2, 1'b0); send_byte(TRAIL_B2, 1'b0); end
            3: begin send_byte(LEAD_C2, 1'b0); send_byte(TRAIL_B3, 1'b0); end
            4: begin
               send_byte(LEAD_E2, 1'b0); send_byte(TRAIL_82, 1'b0);
               send_byte(TRAIL_82, 1'b0);
            end
            default: begin
               send_byte(LEAD_E2, 1'b0); send_byte(TRAIL_82, 1'b0);
               send_byte(TRAIL_83, 1'b0);
            end
         endcase
      end else if (kind < 75) begin
         // some other well-formed character, 2 to 4 bytes
         n = $urandom_range(1, 3);
         if (n == 1)
            send_byte(8'($urandom_range(8'hC2, 8'hDF)), 1'b0);
         else if (n == 2)
            send_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
         else
            send_byte(8'($urandom_range(8'hF0, 8'hF4)), 1'b0);
         repeat (n) send_cont();
      end else if (kind < 83) begin
         // known lead, random continuation: near misses and extra trail bytes
         case ($urandom_range(0, 2))
            0: send_byte(LEAD_C2, 1'b0);
            1: send_byte(LEAD_E2, 1'b0);
            default: begin send_byte(LEAD_E2, 1'b0); send_byte(TRAIL_82, 1'b0); end
         endcase
         repeat ($urandom_range(1, 3)) send_cont();
      end else if (kind < 91) begin
         // lead cut short by a plain character or another lead
         send_byte($urandom_range(0, 1) ? LEAD_C2 : LEAD_E2, 1'b0);
         if ($urandom_range(0, 1))
            send_byte(TRAIL_82, 1'b0);
         send_byte($urandom_range(0, 1) ? 8'($urandom_range(1, 127)) : LEAD_C2, 1'b0);
      end else begin
         send_byte(8'($urandom), 1'b0);   // noise, zero included
      end
   endtask

   task automatic send_string();
      int tokens;
      tokens = $urandom_range(0, 24);
      if ($urandom_range(0, 5) == 0)
         tx_eager = !tx_eager;
      repeat (tokens) send_token();
      if ($urandom_range(0, 2) != 0)
         send_byte(8'($urandom), 1'b1);   // end item, byte is don't-care
      else
         send_byte(NUL_BYTE, 1'b0);       // zero byte ends too
   endtask

   task automatic random_phase(input logic [COUNT_W-1:0] lim, input int items);
      int target;
      set_limit(lim);
      target = req_sent + items;
      while (req_sent < target)
         send_string();
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset limit of 15 ---
      send_byte(8'h41, 1'b0);                                  // plain 'A'
      send_byte(8'h7F, 1'b0);                                  // top ASCII
      send_byte(LEAD_C2, 1'b0); send_byte(TRAIL_B0, 1'b0);     // degree: dropped
      send_byte(LEAD_C2, 1'b0); send_byte(TRAIL_B5, 1'b0);     // micro -> 'u'
      send_byte(LEAD_C2, 1'b0); send_byte(TRAIL_B2, 1'b0);     // sup two
      send_byte(LEAD_C2, 1'b0); send_byte(TRAIL_B3, 1'b0);     // sup three
      send_byte(LEAD_E2, 1'b0); send_byte(TRAIL_82, 1'b0);
      send_byte(TRAIL_82, 1'b0);                               // sub two
      send_byte(LEAD_E2, 1'b0); send_byte(TRAIL_82, 1'b0);
      send_byte(TRAIL_83, 1'b0);                               // sub three
      // failed match on a trail byte, then a further trail byte skipped
      send_byte(LEAD_C2, 1'b0); send_byte(8'hA9, 1'b0); send_byte(8'h80, 1'b0);
      // failed match on a new lead, which then completes
      send_byte(LEAD_E2, 1'b0); send_byte(TRAIL_82, 1'b0);
      send_byte(LEAD_C2, 1'b0); send_byte(TRAIL_B5, 1'b0);
      send_byte(8'h80, 1'b0);                                  // stray trail byte
      send_byte(8'hFF, 1'b0);                                  // invalid lead
      send_byte(8'h42, 1'b0);
      send_byte(8'hAB, 1'b1);                                  // end item
      send_byte(NUL_BYTE, 1'b0);                               // zero byte end

      // limit lowered in the middle of a string
      set_limit(8'd255);
      send_byte(8'h61, 1'b0); send_byte(8'h62, 1'b0); send_byte(8'h63, 1'b0);
      set_limit(8'd1);
      send_byte(8'h64, 1'b0); send_byte(8'h65, 1'b1);

      // zero limit: terminator only
      set_limit(8'd0);
      send_byte(8'h66, 1'b0); send_byte(NUL_BYTE, 1'b0);

      // --- long result stall while bytes keep coming back to back ---
      set_limit(8'd255);
      tx_eager = 1'b1;
      hold_ask <= hold_ask + 1;
      repeat (48) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      send_byte(NUL_BYTE, 1'b1);
      tx_eager = 1'b0;

      // --- random strings under several limits ---
      random_phase(8'($urandom_range(1, 20)), 65);
      random_phase(8'd0, 65);
      random_phase(8'd255, 65);
      random_phase(LIMIT_RESET, 65);
      random_phase(8'($urandom), 65);

      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && waiting_count == 0)
         $display("utf8_ascii_fold: match");
      else
         $display("utf8_ascii_fold: mismatch");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/uaf_pkg.sv
rtl/core/utf8_ascii_fold.sv
rtl/core/uaf_checker.sv
tb/fold_checker.sv
tb/testbench.sv
